>>> sv/upmt_pkg.sv
// ----------------------------------------------------------------------------
// upmt_pkg: shared types and codes of the uuid pattern match table
// Item codes, result codes, sequencer states and the compare result bundle.
// ----------------------------------------------------------------------------
package upmt_pkg;

  localparam int unsigned HALF_W   = 64;
  localparam int unsigned KEY_W    = 2 * HALF_W;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OUT_IX_W = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_CLEAR  = 3'd2,
    MODE_START  = 3'd3,
    MODE_SEEN   = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REC_DONE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_SCAN,
    SQ_MV_RD,
    SQ_MV_WR,
    SQ_INSERT,
    SQ_FIN
  } seq_state_e;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

endpackage

>>> sv/upmt_req_if.sv
// ----------------------------------------------------------------------------
// upmt_req_if: request channel of the uuid pattern match table
// Valid/ready handshake with the item code and the 128-bit uuid.
// ----------------------------------------------------------------------------
interface upmt_req_if;
  import upmt_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [HALF_W-1:0]   uuid_high;
  logic [HALF_W-1:0]   uuid_low;

  modport source (output valid, output mode, output uuid_high, output uuid_low,
                  input ready);
  modport sink   (input valid, input mode, input uuid_high, input uuid_low,
                  output ready);
endinterface

>>> sv/upmt_rsp_if.sv
// ----------------------------------------------------------------------------
// upmt_rsp_if: result channel of the uuid pattern match table
// Valid/ready handshake with status, position, entry count and match flag.
// ----------------------------------------------------------------------------
interface upmt_rsp_if;
  import upmt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [OUT_IX_W-1:0]   position;
  logic [OUT_IX_W-1:0]   entry_count;
  logic                  record_match;

  modport source (output valid, output status, output position,
                  output entry_count, output record_match, input ready);
  modport sink   (input valid, input status, input position,
                  input entry_count, input record_match, output ready);
endinterface

>>> sv/upmt_ram.sv
// ----------------------------------------------------------------------------
// upmt_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module upmt_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 12,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/upmt_key_cmp.sv
// ----------------------------------------------------------------------------
// upmt_key_cmp: shared 128-bit key comparator
// Unsigned equal and less-than of the searched uuid against one table entry.
// ----------------------------------------------------------------------------
module upmt_key_cmp (
  input  logic [upmt_pkg::KEY_W-1:0] key_i,
  input  logic [upmt_pkg::KEY_W-1:0] entry_i,
  output upmt_pkg::cmp_t             res_o
);
  import upmt_pkg::*;

  always_comb begin
    res_o.eq = (key_i == entry_i);
    res_o.lt = (key_i < entry_i);
  end

endmodule

>>> sv/uuid_pattern_match_table.sv
// clear, start record and seen after match go from request straight to the result, with no table scan
// lookups: entries scanned in order by one shared 128-bit comparator, one per cycle
// add/remove: entries shifted one by one through the single ram read port, then an add writes the new key
// throughput: one request at a time; the next one is taken once the result register is free
// reset: count, found marks, match flag, result valid and sequencer clear at once; key ram is not cleared
// ----------------------------------------------------------------------------
// uuid_pattern_match_table: sorted uuid search pattern with per-record match
// Keeps up to MAX_UUIDS sorted 128-bit uuids in a ram, scans them with one
// comparator under a small sequencer, and tracks one found mark per entry.
// ----------------------------------------------------------------------------
module uuid_pattern_match_table #(
  parameter int unsigned MAX_UUIDS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  upmt_req_if.sink   req_i,
  upmt_rsp_if.source rsp_o
);
  import upmt_pkg::*;

  // count holds 0..MAX_UUIDS, ram address covers the entries only
  localparam int unsigned CW = $clog2(MAX_UUIDS + 1);
  localparam int unsigned AW = (MAX_UUIDS > 1) ? $clog2(MAX_UUIDS) : 1;
  localparam int unsigned XW = (CW > OUT_IX_W) ? CW : OUT_IX_W;

  // mask of the n lowest entries
  function automatic logic [MAX_UUIDS-1:0] low_mask(input logic [CW-1:0] n);
    logic [MAX_UUIDS-1:0] m;
    for (int b = 0; b < MAX_UUIDS; b++) begin
      m[b] = (CW'(b) < n);
    end
    return m;
  endfunction

  seq_state_e state_q, state_d;

  // request being worked on
  logic [MODE_W-1:0]    op_mode_q, op_mode_d;
  logic [KEY_W-1:0]     key_q, key_d;

  // pattern state
  logic [CW-1:0]        count_q, count_d;
  logic [MAX_UUIDS-1:0] marks_q, marks_d;
  logic                 rec_done_q, rec_done_d;

  // sequencer working registers
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        mv_dst_q, mv_dst_d;
  logic                 mv_up_q, mv_up_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [CW-1:0]        res_pos_q, res_pos_d;

  // result register
  logic                 out_vld_q, out_vld_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [OUT_IX_W-1:0]  out_pos_q, out_pos_d;
  logic [OUT_IX_W-1:0]  out_cnt_q, out_cnt_d;
  logic                 out_match_q, out_match_d;

  // ram port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_W-1:0]     ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [KEY_W-1:0]     ram_rdata;

  // lookup and decision
  cmp_t                 cmp;
  logic                 req_acc;
  logic                 need_lookup;
  logic                 resolve;
  logic                 lk_done;
  logic                 lk_hit;
  logic [CW-1:0]        lk_pos;
  logic [CW-1:0]        idx_nxt;
  logic                 dec_move;
  logic                 dec_insert;
  logic                 is_full;
  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        cnt_x;

  upmt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_UUIDS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  upmt_key_cmp u_cmp (
    .key_i   (key_q),
    .entry_i (ram_rdata),
    .res_o   (cmp)
  );

  // a new request only once the result register is free
  assign req_i.ready = (state_q == SQ_IDLE) && (!out_vld_q || rsp_o.ready);

  assign req_acc = req_i.valid && req_i.ready;
  assign idx_nxt = CW'(idx_q + 1'b1);
  assign is_full = (count_q >= CW'(MAX_UUIDS));

  // seen after a finished record skips the table
  assign need_lookup = (op_mode_q == MODE_ADD) || (op_mode_q == MODE_REMOVE) ||
                       ((op_mode_q == MODE_SEEN) && !rec_done_q);

  // lookup outcome: ram data in the scan state belongs to entry idx_q
  always_comb begin
    lk_done = 1'b0;
    lk_hit  = 1'b0;
    lk_pos  = '0;
    if (state_q == SQ_EXEC) begin
      // empty pattern: nothing to scan, insertion point is zero
      lk_done = need_lookup && (count_q == '0);
    end else if (state_q == SQ_SCAN) begin
      if (cmp.eq) begin
        lk_done = 1'b1;
        lk_hit  = 1'b1;
        lk_pos  = idx_q;
      end else if (cmp.lt) begin
        lk_done = 1'b1;
        lk_pos  = idx_q;
      end else if (idx_nxt == count_q) begin
        lk_done = 1'b1;
        lk_pos  = count_q;
      end
    end
  end

  assign resolve = lk_done;

  // after the lookup: shift entries, insert directly, or finish
  always_comb begin
    dec_move   = 1'b0;
    dec_insert = 1'b0;
    if (op_mode_q == MODE_ADD) begin
      if (!lk_hit && !is_full) begin
        dec_insert = (lk_pos == count_q);
        dec_move   = (lk_pos != count_q);
      end
    end else if (op_mode_q == MODE_REMOVE) begin
      dec_move = lk_hit && (CW'(lk_pos + 1'b1) != count_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (req_acc) begin
          state_d = SQ_EXEC;
        end
      end
      SQ_EXEC, SQ_SCAN: begin
        if (state_q == SQ_EXEC && !need_lookup) begin
          state_d = SQ_FIN;
        end else if (resolve) begin
          if (dec_move) begin
            state_d = SQ_MV_RD;
          end else if (dec_insert) begin
            state_d = SQ_INSERT;
          end else begin
            state_d = SQ_FIN;
          end
        end else begin
          state_d = SQ_SCAN;
        end
      end
      SQ_MV_RD: begin
        state_d = SQ_MV_WR;
      end
      SQ_MV_WR: begin
        if (mv_up_q) begin
          if (CW'(mv_dst_q - 1'b1) == res_pos_q) begin
            state_d = SQ_INSERT;
          end else begin
            state_d = SQ_MV_RD;
          end
        end else if (CW'(mv_dst_q + 1'b1) == count_q) begin
          state_d = SQ_FIN;
        end else begin
          state_d = SQ_MV_RD;
        end
      end
      SQ_INSERT: begin
        state_d = SQ_FIN;
      end
      SQ_FIN: begin
        state_d = SQ_IDLE;
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase
  end

  // datapath, ram port and handshake
  always_comb begin
    op_mode_d    = op_mode_q;
    key_d        = key_q;
    count_d      = count_q;
    marks_d      = marks_q;
    rec_done_d   = rec_done_q;
    idx_d        = idx_q;
    mv_dst_d     = mv_dst_q;
    mv_up_d      = mv_up_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_cnt_d    = out_cnt_q;
    out_match_d  = out_match_q;
    ram_we       = 1'b0;
    ram_waddr    = mv_dst_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = '0;
    pos_x        = XW'(res_pos_q);
    cnt_x        = XW'(count_q);

    // result register frees up when taken
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      SQ_IDLE: begin
        if (req_acc) begin
          op_mode_d = req_i.mode;
          key_d     = {req_i.uuid_high, req_i.uuid_low};
        end
      end
      SQ_EXEC, SQ_SCAN: begin
        if (state_q == SQ_EXEC) begin
          idx_d        = '0;
          res_status_d = ST_DONE;
          res_pos_d    = '0;
          if (!need_lookup) begin
            case (op_mode_q)
              MODE_CLEAR: begin
                count_d    = '0;
                marks_d    = '0;
                rec_done_d = 1'b0;
              end
              MODE_START: begin
                marks_d    = '0;
                rec_done_d = 1'b0;
              end
              MODE_SEEN: begin
                res_status_d = ST_REC_DONE;
              end
              default: begin
                res_status_d = ST_DONE;
              end
            endcase
          end
        end else begin
          idx_d = idx_nxt;
          // prefetch the next entry while this one is compared
          if (idx_nxt < count_q) begin
            ram_raddr = idx_nxt[AW-1:0];
          end
        end

        if (resolve) begin
          res_pos_d    = lk_pos;
          res_status_d = ST_DONE;
          case (op_mode_q)
            MODE_ADD: begin
              if (lk_hit) begin
                res_status_d = ST_PRESENT;
              end else if (is_full) begin
                res_status_d = ST_FULL;
              end else begin
                // marks move up with their entries, the new entry unmarked
                count_d  = CW'(count_q + 1'b1);
                marks_d  = ((marks_q & low_mask(lk_pos)) |
                            ((marks_q & ~low_mask(lk_pos)) << 1)) &
                           low_mask(CW'(count_q + 1'b1));
                mv_dst_d = count_q;
                mv_up_d  = 1'b1;
              end
            end
            MODE_REMOVE: begin
              if (!lk_hit) begin
                res_status_d = ST_NOT_FOUND;
              end else begin
                count_d  = CW'(count_q - 1'b1);
                marks_d  = (marks_q & low_mask(lk_pos)) |
                           ((marks_q & ~low_mask(CW'(lk_pos + 1'b1))) >> 1);
                mv_dst_d = lk_pos;
                mv_up_d  = 1'b0;
              end
            end
            MODE_SEEN: begin
              if (!lk_hit) begin
                res_status_d = ST_NOT_FOUND;
              end else if ((marks_q & (MAX_UUIDS'(1'b1) << lk_pos)) != '0) begin
                res_status_d = ST_PRESENT;
              end else begin
                marks_d    = marks_q | (MAX_UUIDS'(1'b1) << lk_pos);
                rec_done_d = ((marks_q | (MAX_UUIDS'(1'b1) << lk_pos)) ==
                              low_mask(count_q));
              end
            end
            default: begin
              res_status_d = ST_DONE;
            end
          endcase
        end
      end
      SQ_MV_RD: begin
        // source is the neighbor toward the gap
        if (mv_up_q) begin
          ram_raddr = mv_dst_q[AW-1:0] - 1'b1;
        end else begin
          ram_raddr = mv_dst_q[AW-1:0] + 1'b1;
        end
      end
      SQ_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = mv_dst_q[AW-1:0];
        ram_wdata = ram_rdata;
        if (mv_up_q) begin
          mv_dst_d = CW'(mv_dst_q - 1'b1);
        end else begin
          mv_dst_d = CW'(mv_dst_q + 1'b1);
        end
      end
      SQ_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = res_pos_q[AW-1:0];
        ram_wdata = key_q;
      end
      SQ_FIN: begin
        out_vld_d    = 1'b1;
        out_status_d = res_status_q;
        out_pos_d    = pos_x[OUT_IX_W-1:0];
        out_cnt_d    = cnt_x[OUT_IX_W-1:0];
        out_match_d  = rec_done_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SQ_IDLE;
      count_q    <= '0;
      marks_q    <= '0;
      rec_done_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      marks_q    <= marks_d;
      rec_done_q <= rec_done_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload and working registers need no reset
  always_ff @(posedge clk_i) begin
    op_mode_q    <= op_mode_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    mv_dst_q     <= mv_dst_d;
    mv_up_q      <= mv_up_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_cnt_q    <= out_cnt_d;
    out_match_q  <= out_match_d;
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.position     = out_pos_q;
  assign rsp_o.entry_count  = out_cnt_q;
  assign rsp_o.record_match = out_match_q;

`ifndef NO_ASSERTIONS
  // the result register is always free while a request is in flight
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SQ_IDLE) |-> !out_vld_q)
    else $error("result pending while sequencer busy");

  // the pattern never grows beyond the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_UUIDS))
    else $error("entry count above table depth");

  // found marks only on live entries
  a_marks_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (marks_q & ~low_mask(count_q)) == '0)
    else $error("found mark beyond entry count");

  // an accepted request starts the sequencer
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == SQ_EXEC))
    else $error("accepted request not started");
`endif

endmodule
